// File: design/swj_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window jitter package
// Sizes, widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package swj_pkg;

  localparam int Window    = 32;
  localparam int SampleW   = 16;
  localparam int SlotW     = (Window > 1) ? $clog2(Window) : 1;
  localparam int CountW    = $clog2(Window + 1);
  localparam int SumW      = SampleW + $clog2(Window);
  localparam int SqW       = 2 * SampleW + $clog2(Window);
  localparam int ProdW     = CountW + SqW;
  localparam int VarW      = 2 * SumW;
  localparam int FracShift = 16;
  localparam int RadW      = VarW + FracShift;
  localparam int RootW     = RadW / 2;
  localparam int RemW      = RootW + 2;
  localparam int StepW     = $clog2(RootW);
  localparam int JitW      = 23;
  localparam int CntOutW   = 6;

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdClear = 1'b1;

  typedef struct packed {
    logic load;       // latch the accepted request
    logic clear;      // empty the window
    logic read;       // read the ring at the write slot
    logic update;     // update sums, ring, slot and count
    logic mult;       // form n*S2 and S1*S1
    logic setup;      // form the variance numerator, start the root
    logic sqrt_step;  // one root digit
    logic step_load;  // reload the step counter
    logic div_step;   // one quotient bit
    logic load_out;   // move the result into the output register
  } swj_cmd_t;

  typedef struct packed {
    logic step_last;
  } swj_status_t;

endpackage

`default_nettype wire

// File: design/swj_if.sv
// ----------------------------------------------------------------------------
// Sliding window jitter channels
// Request channel (samples and clears) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface swj_in_if;
  import swj_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SampleW-1:0] latency_ms;

  modport source (output valid, output cmd, output latency_ms, input ready);
  modport sink (input valid, input cmd, input latency_ms, output ready);
endinterface

interface swj_out_if;
  import swj_pkg::*;

  logic               valid;
  logic               ready;
  logic [JitW-1:0]    jitter_q8;
  logic [CntOutW-1:0] sample_count;

  modport source (output valid, output jitter_q8, output sample_count, input ready);
  modport sink (input valid, input jitter_q8, input sample_count, output ready);
endinterface

`default_nettype wire

// File: design/swj_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window jitter controller
// Sequences each sample through update, root and divide, owns result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module swj_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  sample_valid,
  input  wire                  sample_cmd,
  output logic                 sample_ready,
  output logic                 result_valid,
  input  wire                  result_ready,
  output swj_pkg::swj_cmd_t    cmd,
  input  swj_pkg::swj_status_t status
);
  import swj_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUB  = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state, state_next;
  logic       out_valid, out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load = 1'b1;
          if (sample_cmd == CmdClear) begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mult   = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.setup  = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.step_last) begin
          cmd.step_load = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // The previous result must be gone before this one replaces it.
        if (!out_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (result_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign sample_ready = (state == S_IDLE);
  assign result_valid = out_valid;

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || result_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result was not presented");

  a_add_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && sample_valid && sample_cmd == CmdAdd) |=> (state == S_READ))
    else $error("accepted sample did not start the update");

endmodule

`default_nettype wire

// File: design/swj_dp.sv
// ----------------------------------------------------------------------------
// Sliding window jitter datapath
// Sample ring, running sums, digit-serial square root and bit-serial divide.
// ----------------------------------------------------------------------------
`default_nettype none

module swj_dp (
  input  wire                         clk,
  input  wire                         rst,
  input  swj_pkg::swj_cmd_t           cmd,
  output swj_pkg::swj_status_t        status,
  input  wire [swj_pkg::SampleW-1:0]  latency_ms,
  output logic [swj_pkg::JitW-1:0]    jitter_q8,
  output logic [swj_pkg::CntOutW-1:0] sample_count
);
  import swj_pkg::*;

  logic [SampleW-1:0]   ring [Window];
  logic [SampleW-1:0]   rd_data;
  logic [SampleW-1:0]   x;
  logic [2*SampleW-1:0] x_sq;
  logic [SlotW-1:0]     slot;
  logic [CountW-1:0]    count;
  logic [SumW-1:0]      sum;
  logic [SqW-1:0]       sq;
  logic [ProdW-1:0]     prod_n;
  logic [VarW-1:0]      prod_s;
  logic [RadW-1:0]      rad;
  logic [RootW-1:0]     root;
  logic [RemW-1:0]      rem;
  logic [CountW-1:0]    drem;
  logic [StepW-1:0]     step;

  logic                 full;
  logic [SampleW-1:0]   old;
  logic [2*SampleW-1:0] old_sq;
  logic [VarW-1:0]      var_full;
  logic [RemW+1:0]      rem_sh;
  logic [RemW+1:0]      trial;
  logic                 root_fits;
  logic [CountW:0]      div_t;
  logic                 div_fits;

  assign full   = (count == CountW'(Window));
  // Once the ring is full the write slot holds the oldest sample.
  assign old    = full ? rd_data : '0;
  assign old_sq = (2*SampleW)'(old) * (2*SampleW)'(old);

  assign var_full = VarW'(prod_n - ProdW'(prod_s));

  assign rem_sh    = {rem, rad[RadW-1 -: 2]};
  assign trial     = (RemW + 2)'({root, 2'b01});
  assign root_fits = (rem_sh >= trial);

  assign div_t    = {drem, root[RootW-1]};
  assign div_fits = (div_t >= (CountW + 1)'(count));

  assign status.step_last = (step == '0);

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= ring[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ring[slot] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
      sq    <= '0;
    end else if (cmd.clear) begin
      slot  <= '0;
      count <= '0;
      sum   <= '0;
      sq    <= '0;
    end else if (cmd.update) begin
      slot  <= (slot == SlotW'(Window - 1)) ? '0 : slot + SlotW'(1);
      count <= full ? count : count + CountW'(1);
      sum   <= sum - SumW'(old) + SumW'(x);
      sq    <= sq - SqW'(old_sq) + SqW'(x_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= latency_ms;
    end
    if (cmd.read) begin
      x_sq <= (2*SampleW)'(x) * (2*SampleW)'(x);
    end
    if (cmd.mult) begin
      prod_n <= ProdW'(count) * ProdW'(sq);
      prod_s <= VarW'(sum) * VarW'(sum);
    end

    if (cmd.setup || cmd.step_load) begin
      step <= StepW'(RootW - 1);
    end else if (cmd.sqrt_step || cmd.div_step) begin
      step <= step - StepW'(1);
    end

    if (cmd.clear) begin
      root <= '0;
    end else if (cmd.setup) begin
      rad  <= {var_full, {FracShift{1'b0}}};
      root <= '0;
      rem  <= '0;
      drem <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= rad << 2;
      if (root_fits) begin
        rem  <= RemW'(rem_sh - trial);
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        rem  <= RemW'(rem_sh);
        root <= {root[RootW-2:0], 1'b0};
      end
    end else if (cmd.div_step) begin
      // The root register shifts out dividend bits and takes quotient bits.
      if (div_fits) begin
        drem <= CountW'(div_t - (CountW + 1)'(count));
      end else begin
        drem <= CountW'(div_t);
      end
      root <= {root[RootW-2:0], div_fits};
    end

    if (cmd.load_out) begin
      jitter_q8    <= JitW'(root);
      sample_count <= CntOutW'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CountW'(Window)))
    else $error("sample count exceeds the window");

  a_empty_sums: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (sum == '0 && sq == '0))
    else $error("empty window holds nonzero sums");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (slot <= SlotW'(Window - 1)))
    else $error("write slot outside the ring");

endmodule

`default_nettype wire

// File: design/sliding_window_jitter_stddev.sv
// ----------------------------------------------------------------------------
// Sliding window jitter, population standard deviation
// Window of latency samples, result in unsigned fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
// A sample request runs the 29 root digit steps and then the 29 divide steps,
// which share the root register; a clear request goes straight to the output
// register. A new request is taken only once the previous result has been
// loaded. The ring holds no reset value; its read data is used only once the
// ring is full, when every slot is written. Synchronous reset empties the window.
`default_nettype none

module sliding_window_jitter_stddev (
  input wire          clk,
  input wire          rst,
  swj_in_if.sink      sample,
  swj_out_if.source   result
);
  import swj_pkg::*;

  swj_cmd_t    cmd;
  swj_status_t status;

  swj_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_cmd   (sample.cmd),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd),
    .status       (status)
  );

  swj_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .latency_ms   (sample.latency_ms),
    .jitter_q8    (result.jitter_q8),
    .sample_count (result.sample_count)
  );

endmodule

`default_nettype wire

// File: dv/sliding_window_jitter_stddev_test.sv
// ----------------------------------------------------------------------------
// Sliding window jitter testbench
// Sends sample and clear requests, tracks the window contents, sums and the
// floored standard deviation in its own model, and checks each result field.
// ----------------------------------------------------------------------------
module sliding_window_jitter_stddev_test;
  import swj_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = 80;
  localparam int LongHold   = 600;

  typedef struct {
    logic               cmd;
    logic [SampleW-1:0] latency_ms;
    int                 gap;
    bit                 drain;
  } sample_req_t;

  typedef struct {
    logic [JitW-1:0]    jitter_q8;
    logic [CntOutW-1:0] sample_count;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swj_in_if  sample_ch ();
  swj_out_if result_ch ();

  sliding_window_jitter_stddev u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sample_req_t   sample_backlog[$];
  window_stats_t stats_due[$];
  int            errors = 0;
  int            cycles = 0;

  // Window model: ring, fill level and the two running sums.
  logic [SampleW-1:0] win_ring [Window];
  int                 win_slot = 0;
  int                 win_held = 0;
  logic [63:0]        win_sum  = '0;
  logic [63:0]        win_sq   = '0;

  // Floored square root of v * 65536, two radicand bits per digit.
  function automatic logic [39:0] sqrt_q16(input logic [63:0] v);
    logic [79:0] rad;
    logic [43:0] rem;
    logic [41:0] trial;
    logic [39:0] root;
    rad  = {v, 16'h0000};
    rem  = '0;
    root = '0;
    for (int i = 0; i < 40; i++) begin
      rem   = {rem[41:0], rad[79-2*i -: 2]};
      trial = {root, 2'b01};
      if (rem >= {2'b00, trial}) begin
        rem  = rem - {2'b00, trial};
        root = {root[38:0], 1'b1};
      end else begin
        root = {root[38:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic void advance_window(input logic cmd, input logic [SampleW-1:0] x);
    window_stats_t st;
    logic [63:0]   old;
    logic [63:0]   xv;
    logic [63:0]   n;
    logic [63:0]   var_num;
    logic [63:0]   jit;
    if (cmd == CmdClear) begin
      win_slot = 0;
      win_held = 0;
      win_sum  = '0;
      win_sq   = '0;
      st.jitter_q8    = '0;
      st.sample_count = '0;
    end else begin
      xv = 64'(x);
      if (win_held >= Window) begin
        // The slot about to be overwritten holds the oldest sample.
        old     = 64'(win_ring[win_slot]);
        win_sum = win_sum - old;
        win_sq  = win_sq - old * old;
      end else begin
        win_held++;
      end
      win_ring[win_slot] = x;
      win_sum  = win_sum + xv;
      win_sq   = win_sq + xv * xv;
      win_slot = (win_slot + 1) % Window;
      n        = 64'(win_held);
      var_num  = n * win_sq - win_sum * win_sum;
      jit      = 64'(sqrt_q16(var_num)) / n;
      st.jitter_q8    = jit[JitW-1:0];
      st.sample_count = n[CntOutW-1:0];
    end
    stats_due.insert(stats_due.size(), st);
  endfunction

  task automatic add_request(input logic cmd, input logic [SampleW-1:0] lat,
                             input bit drain);
    sample_req_t r;
    r.cmd        = cmd;
    r.latency_ms = lat;
    r.drain      = drain;
    // Every third block of sixty requests goes out back to back.
    if ((sample_backlog.size() / 60) % 3 == 1) r.gap = 0;
    else r.gap = $urandom_range(0, 18);
    sample_backlog.insert(sample_backlog.size(), r);
  endtask

  // Driver: offers the oldest pending request, holding it until accepted.
  int gap_count = 0;
  always @(posedge clk) begin
    sample_req_t r;
    logic        next_valid;
    if (rst) begin
      sample_ch.valid      <= 1'b0;
      sample_ch.cmd        <= CmdAdd;
      sample_ch.latency_ms <= '0;
      gap_count = 0;
    end else begin
      next_valid = sample_ch.valid;
      if (sample_ch.valid && sample_ch.ready) begin
        advance_window(sample_ch.cmd, sample_ch.latency_ms);
        next_valid = 1'b0;
      end
      if (!next_valid && sample_backlog.size() > 0) begin
        if (sample_backlog[0].drain && stats_due.size() > 0) begin
          gap_count = 0;
        end else if (gap_count < sample_backlog[0].gap) begin
          gap_count++;
        end else begin
          r = sample_backlog.pop_front();
          sample_ch.cmd        <= r.cmd;
          sample_ch.latency_ms <= r.latency_ms;
          next_valid = 1'b1;
          gap_count  = 0;
        end
      end
      sample_ch.valid <= next_valid;
    end
  end

  // Result side back-pressure, with one long hold-off partway through.
  int taken      = 0;
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        taken++;
        if ((taken / 50) % 3 == 2) stall_left = 0;
        else stall_left = $urandom_range(0, 18);
        if (taken == 150) hold_left = LongHold;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      result_ch.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // Monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    window_stats_t st;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result jitter_q8=%0d sample_count=%0d", $time,
                 result_ch.jitter_q8, result_ch.sample_count);
        errors++;
      end else begin
        st = stats_due.pop_front();
        if (result_ch.jitter_q8 !== st.jitter_q8) begin
          $display("%0t: jitter_q8 expected %0d actual %0d", $time, st.jitter_q8,
                   result_ch.jitter_q8);
          errors++;
        end
        if (result_ch.sample_count !== st.sample_count) begin
          $display("%0t: sample_count expected %0d actual %0d", $time,
                   st.sample_count, result_ch.sample_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [SampleW-1:0] draw_latency(input int style,
                                                      input logic [SampleW-1:0] base);
    logic [SampleW-1:0] v;
    case (style)
      0, 1, 2, 3: v = SampleW'($urandom);
      4, 5: begin
        if ($urandom_range(0, 1) == 1) v = 16'hFFFF - SampleW'($urandom_range(0, 3));
        else v = SampleW'($urandom_range(0, 3));
      end
      6, 7, 8: v = base + SampleW'($urandom_range(0, 40)) - 16'd20;
      default: v = SampleW'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  initial begin
    logic [SampleW-1:0] base;
    int                 style;

    // Directed: clear on an empty window, single samples, widest spread,
    // equal samples and alternating bit patterns.
    add_request(CmdClear, 16'h0000, 1'b0);
    add_request(CmdAdd,   16'h0000, 1'b0);
    add_request(CmdAdd,   16'h0000, 1'b0);
    add_request(CmdClear, 16'hFFFF, 1'b0);
    add_request(CmdAdd,   16'hFFFF, 1'b0);
    add_request(CmdAdd,   16'h0000, 1'b0);
    add_request(CmdAdd,   16'hFFFF, 1'b0);
    add_request(CmdAdd,   16'h0000, 1'b0);
    add_request(CmdClear, 16'h1234, 1'b0);
    add_request(CmdAdd,   16'd1,    1'b0);
    add_request(CmdAdd,   16'd2,    1'b0);
    add_request(CmdAdd,   16'd3,    1'b0);
    add_request(CmdAdd,   16'h8000, 1'b0);
    add_request(CmdAdd,   16'h7FFF, 1'b0);
    add_request(CmdAdd,   16'hAAAA, 1'b0);
    add_request(CmdAdd,   16'h5555, 1'b0);
    add_request(CmdClear, 16'h0000, 1'b0);
    add_request(CmdAdd,   16'hFFFF, 1'b0);
    add_request(CmdAdd,   16'hFFFF, 1'b0);
    add_request(CmdClear, 16'h0000, 1'b0);

    // Random: long runs of samples so the window fills and wraps, with the
    // occasional clear. Styles switch now and then to vary the spread.
    base  = SampleW'($urandom);
    style = 0;
    for (int i = 0; i < 500; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        style = $urandom_range(0, 9);
        base  = SampleW'($urandom);
      end
      if ($urandom_range(0, 59) == 0)
        add_request(CmdClear, SampleW'($urandom), (i == 40) || (i == 350));
      else
        add_request(CmdAdd, draw_latency(style, base), (i == 40) || (i == 350));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sample_backlog.size() > 0 || sample_ch.valid || stats_due.size() > 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
